### hw/rtl/dpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths, microcode format and digit helpers for the decimal
// product digit block.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int FACTOR_W   = 31;
  localparam int PROD_W     = 2 * FACTOR_W;
  localparam int BCD_DIGITS = 19;               // enough for any 62-bit product
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int MAX_DIGITS = 19;
  localparam int CAP        = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
  localparam int PASSES     = PROD_W / 2;       // two product bits per pass
  localparam int CNT_W      = $clog2(PASSES + 1);
  localparam int PTR_W      = $clog2(BCD_DIGITS);
  localparam int DIGIT_W    = 4;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // Program counter of the sequencer
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_DABBLE = 2'd1;
  localparam step_t STEP_FIND   = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  // Jump conditions: the step holds until its condition is true,
  // then jumps to its target
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_XFER,
    COND_CNT_DONE,
    COND_LAST_SENT
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  dabble;
    logic  find;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctl_t;

  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    w = '{take_in: 1'b0, dabble: 1'b0, find: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_IN_XFER;
        w.target  = STEP_DABBLE;
      end
      STEP_DABBLE: begin
        w.dabble = 1'b1;
        w.cond   = COND_CNT_DONE;
        w.target = STEP_FIND;
      end
      STEP_FIND: begin
        w.find   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_LAST_SENT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // One shift-add-3 step: correct each digit, then shift in one binary bit
  function automatic bcd_t dabble_bit(input bcd_t b, input logic bit_in);
    bcd_t           c;
    logic [BCD_W:0] sh;
    c = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (c[i] >= 4'd5) begin
        c[i] = c[i] + 4'd3;
      end
    end
    sh = {c, bit_in};
    return bcd_t'(sh[BCD_W-1:0]);
  endfunction

endpackage

### hw/rtl/decimal_product_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_product_digits
// Multiplies two 31-bit factors and streams the decimal digits of the
// product, most significant first, with last_digit on the final one.
// ----------------------------------------------------------------------------
// One operand pair is handled at a time. After the input transfer the block
// turns the 62-bit product into decimal (shift-add-3, two product bits per
// cycle), then locates the leading digit, then puts the digits out one per
// free output slot, so a stalled output holds the run. A zero product yields
// the single digit 0. in_ready is high only while the sequencer waits at its
// idle step; the last digit may still sit in the output register while the
// next pair is taken. Control is a four-step microprogram in a constant
// table: each step holds until its jump condition is met, then branches to
// its target.
// ----------------------------------------------------------------------------
module decimal_product_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dpd_pkg::FACTOR_W-1:0]  in_multiplicand,
  input  logic [dpd_pkg::FACTOR_W-1:0]  in_multiplier,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dpd_pkg::DIGIT_W-1:0]   out_digit,
  output logic                          out_last_digit
);
  import dpd_pkg::*;

  step_t             pc_r, pc_nxt;
  ctl_t              ctl;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] mul_w;
  bcd_t              bcd_r, bcd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  lead;
  logic              out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic              out_last_r, out_last_nxt;
  logic              in_xfer;
  logic              out_free;
  logic              emit_go;
  logic              jump;

  // Fetch the control word for the current step
  assign ctl = ucode(pc_r);

  assign in_ready = ctl.take_in;
  assign in_xfer  = in_valid && ctl.take_in;
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = ctl.emit && out_free;

  // Single 31x31 multiply, registered into prod_r
  assign mul_w = PROD_W'(in_multiplicand) * PROD_W'(in_multiplier);

  // Leading nonzero digit, capped to the digit register length
  always_comb begin
    lead = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead = PTR_W'(i);
      end
    end
    if (lead > PTR_W'(CAP - 1)) begin
      lead = PTR_W'(CAP - 1);
    end
  end

  // Jump condition select
  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:    jump = 1'b1;
      COND_IN_XFER:   jump = in_xfer;
      COND_CNT_DONE:  jump = (cnt_r == CNT_W'(1));
      COND_LAST_SENT: jump = emit_go && (ptr_r == '0);
      default:        jump = 1'b1;
    endcase
  end

  // Datapath driven by the control word
  always_comb begin
    pc_nxt        = jump ? ctl.target : pc_r;
    prod_nxt      = prod_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;

    // Drop the output item once it transfers
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_xfer) begin
      prod_nxt = mul_w;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(PASSES);
    end

    // Convert two product bits per cycle, top bit first
    if (ctl.dabble) begin
      bcd_nxt  = dabble_bit(dabble_bit(bcd_r, prod_r[PROD_W-1]), prod_r[PROD_W-2]);
      prod_nxt = {prod_r[PROD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end

    if (ctl.find) begin
      ptr_nxt = lead;
    end

    // Advance one digit per free output slot
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = bcd_r[ptr_r];
      out_last_nxt  = (ptr_r == '0);
      ptr_nxt       = ptr_r - PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    bcd_r       <= bcd_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

endmodule

### hw/rtl/dpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks for the decimal product digit block.
// ----------------------------------------------------------------------------
module dpd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dpd_pkg::DIGIT_W-1:0]   out_digit,
  input logic                          out_last_digit
);
  import dpd_pkg::*;

  // Hold a stalled output transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) && $stable(out_last_digit))
    else $error("output changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit <= 4'd9)
    else $error("digit out of decimal range");

  // A new pair is taken only after the previous run has ended
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |-> !in_ready)
    else $error("input ready in the middle of a digit run");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !(out_valid && !out_last_digit))
    else $error("sequencer did not start converting");

endmodule

bind decimal_product_digits dpd_checker u_dpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digit       (out_digit),
  .out_last_digit  (out_last_digit)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the decimal product digit stream against an internal long-division
// predictor. Operand pairs go in through a valid/ready channel; every digit
// transfer on the output is compared with the oldest predicted digit.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FW          = dpd_pkg::FACTOR_W;
  localparam int DW          = dpd_pkg::DIGIT_W;
  localparam int DIGIT_SLOTS = 20;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_ITEMS  = 70;     // random items sent with no idling at all
  localparam int HOLD_CYCLES = 400;    // receiver hold-off used to back up the input
  localparam int DRAIN_CYCLES = 60;    // wait for any stray digit after the drain
  localparam int STALL_LIMIT = 4000;   // cycles without any transfer before giving up
  localparam int MAX_REPORTS = 10;

  localparam logic [FW-1:0] FACTOR_MAX = {FW{1'b1}};

  typedef struct {
    logic [DW-1:0] digit;
    logic          last_digit;
  } digit_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the digits of each accepted pair and checks the
  // output stream against them in order.
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    digit_rec_t pending_digits[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Predict the digits of a*b, most significant first.
    function void note_pair(logic [FW-1:0] a, logic [FW-1:0] b);
      logic [63:0]   prod;
      logic [DW-1:0] lsd_first[DIGIT_SLOTS];
      int            count;
      int            cap;
      digit_rec_t    rec;
      prod  = 64'(a) * 64'(b);
      count = 0;
      do begin
        lsd_first[count] = DW'(prod % 64'd10);
        prod = prod / 64'd10;
        count++;
      end while (prod != 64'd0 && count < DIGIT_SLOTS);
      cap = dpd_pkg::MAX_DIGITS;
      if (cap < 1) begin
        cap = 1;
      end
      if (cap > DIGIT_SLOTS) begin
        cap = DIGIT_SLOTS;
      end
      if (count > cap) begin
        count = cap;
      end
      for (int k = 0; k < count; k++) begin
        rec.digit      = lsd_first[count - 1 - k];
        rec.last_digit = (k == count - 1);
        pending_digits.push_back(rec);
      end
    endfunction

    function void check_digit(logic [DW-1:0] digit, logic last_digit);
      digit_rec_t exp_rec;
      if (pending_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected digit %0d last_digit %0b at %0t", digit, last_digit, $realtime);
        end
        return;
      end
      exp_rec = pending_digits.pop_front();
      if (digit !== exp_rec.digit || last_digit !== exp_rec.last_digit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("digit mismatch at %0t: digit exp %0d got %0d, last_digit exp %0b got %0b",
                   $realtime, exp_rec.digit, digit, exp_rec.last_digit, last_digit);
        end
      end
    endfunction

    function int outstanding();
      return pending_digits.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic          clk             = 1'b0;
  logic          rst_n           = 1'b0;
  logic          in_valid        = 1'b0;
  logic          in_ready;
  logic [FW-1:0] in_multiplicand = '0;
  logic [FW-1:0] in_multiplier   = '0;
  logic          out_valid;
  logic          out_ready       = 1'b0;
  logic [DW-1:0] out_digit;
  logic          out_last_digit;

  // Idling controls shared between the stimulus and the receiver
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit hold_off_req = 1'b0;

  digit_scoreboard sb = new();

  always #6 clk = ~clk;

  decimal_product_digits u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_multiplicand (in_multiplicand),
    .in_multiplier   (in_multiplier),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit       (out_digit),
    .out_last_digit  (out_last_digit)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, before the block's
  // registers move, and feed every transfer to the scoreboard.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_digit(out_digit, out_last_digit);
      end
      if (in_valid && in_ready) begin
        sb.note_pair(in_multiplicand, in_multiplier);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drive out_ready at the falling edge. On request, hold off for a
  // long stretch so the block backs up and drops in_ready while the sender
  // keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready    = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          @(negedge clk);
        end
      end
      out_ready = rx_idle ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Call at a falling edge; returns at the falling edge after the
  // transfer. Valid stays high with a steady payload until accepted.
  // --------------------------------------------------------------------------
  task automatic send_pair(input logic [FW-1:0] a, input logic [FW-1:0] b);
    while (tx_idle && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_multiplicand = a;
    in_multiplier   = b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // Pick a factor: mostly full width or a random bit length, some small
  // values, a few near the top and an occasional zero.
  function automatic logic [FW-1:0] pick_factor();
    logic [FW-1:0] v;
    case ($urandom_range(19))
      0:       v = '0;
      1, 2, 3: v = FW'($urandom_range(99));
      4, 5, 6, 7, 8, 9: v = FW'($urandom) >> $urandom_range(FW - 1);
      10, 11, 12, 13, 14, 15, 16, 17: v = FW'($urandom);
      default: v = FACTOR_MAX - FW'($urandom_range(15));
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero factors, extremes, carries, trailing zeros, 19 digits
    send_pair('0, '0);
    send_pair('0, FACTOR_MAX);
    send_pair(FACTOR_MAX, '0);
    send_pair(31'd1, 31'd1);
    send_pair(31'd3, 31'd3);
    send_pair(31'd2, 31'd5);
    send_pair(FACTOR_MAX, FACTOR_MAX);
    send_pair(31'd1, FACTOR_MAX);
    send_pair(FACTOR_MAX, 31'd1);
    send_pair(31'd99999, 31'd99999);
    send_pair(31'd100000, 31'd100000);
    send_pair(31'd1000000000, 31'd1000000000);
    send_pair(31'd999999999, 31'd9);
    send_pair(31'h55555555, 31'h2AAAAAAA);
    send_pair(31'h40000000, 31'h40000000);

    // Random: a calm stretch, a hold-off on the receiver, then idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (n == CALM_ITEMS) begin
        hold_off_req = 1'b1;
      end
      if (n == CALM_ITEMS + 20) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      send_pair(pick_factor(), pick_factor());
    end
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray digit
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
